>>> hdl/ibt_pkg.sv
// Shared constants, types and status codes for the interval booking table.
`timescale 1ns / 1ps
package ibt_pkg;

    localparam int CAPACITY   = 64;
    localparam int TIME_BITS  = 32;
    localparam int SLOT_BITS  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = 2 * TIME_BITS;

    localparam int FIELD_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int BOOKED_BITS = 7;

    typedef logic [TIME_BITS-1:0]  time_t;
    typedef logic [SLOT_BITS-1:0]  slot_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [ENTRY_BITS-1:0] entry_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_BOOKED  = 2'd0,
        ST_OVERLAP = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

endpackage

>>> hdl/ibt_req_if.sv
// Request channel: one interval per item.
`timescale 1ns / 1ps
interface ibt_req_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_time;
    logic [31:0] end_time;

    modport source (output valid, output start_time, output end_time, input ready);
    modport sink   (input valid, input start_time, input end_time, output ready);
endinterface

>>> hdl/ibt_rsp_if.sv
// Response channel: status and booking count per item.
`timescale 1ns / 1ps
interface ibt_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [6:0] booked_count;

    modport source (output valid, output status, output booked_count, input ready);
    modport sink   (input valid, input status, input booked_count, output ready);
endinterface

>>> hdl/ibt_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module ibt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/ibt_overlap.sv
// Half-open interval overlap compare, shared by every slot of the scan.
`timescale 1ns / 1ps
module ibt_overlap import ibt_pkg::*; (
    input  entry_t slot_entry,
    input  time_t  req_start,
    input  time_t  req_end,
    output logic   hit
);

    time_t slot_start;
    time_t slot_end;

    // entry packs {start, end}
    assign slot_start = slot_entry[ENTRY_BITS-1:TIME_BITS];
    assign slot_end   = slot_entry[TIME_BITS-1:0];

    assign hit = (slot_start < req_end) && (slot_end > req_start);

endmodule

>>> hdl/interval_booking_table_unit.sv
// Interval booking table: top level with scan sequencer, valid bits and slot RAM.
//
//  channel | dir | payload                          | accepted when
//  --------+-----+----------------------------------+-------------------------
//  req     | in  | start_time[31:0], end_time[31:0] | req.valid && req.ready
//  rsp     | out | status[1:0], booked_count[6:0]   | rsp.valid && rsp.ready
//
// An empty or inverted interval goes from accept straight to the reply step. Any
// other item walks all CAPACITY slots through the single read port of the slot
// RAM, one slot per cycle, in these steps from accept to result: accept,
// CAPACITY reads, RAM drain, decide/write, reply.
// req.ready is high only while idle. The result sits in an output register;
// a stalled rsp holds the sequencer in its reply step until the register frees.
// Reset clears valid bits, count and control at once; no clearing pass.
`timescale 1ns / 1ps
module interval_booking_table_unit import ibt_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    ibt_req_if.sink   req,
    ibt_rsp_if.source rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_REPLY
    } state_t;

    state_t                     state_reg;
    time_t                      start_reg;
    time_t                      end_reg;
    slot_t                      idx_reg;
    slot_t                      free_idx_reg;
    logic                       have_free_reg;
    logic                       clash_reg;
    logic                       p_vld_reg;       // RAM read in flight
    logic                       p_slot_valid_reg;
    logic [CAPACITY-1:0]        slot_valid_reg;
    count_t                     held_count_reg;
    status_t                    result_reg;
    logic                       rsp_valid_reg;
    status_t                    rsp_status_reg;
    logic [BOOKED_BITS-1:0]     rsp_booked_reg;

    time_t   req_start;
    time_t   req_end;
    entry_t  rd_entry;
    logic    hit;
    logic    ram_we;
    logic    req_fire;
    logic    booking;
    logic    reply_load;

    assign req_start = TIME_BITS'(req.start_time);
    assign req_end   = TIME_BITS'(req.end_time);
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign booking = !clash_reg && have_free_reg;
    assign ram_we  = (state_reg == S_DECIDE) && booking;

    // output register can take a new item when empty or being drained
    assign reply_load = (state_reg == S_REPLY) && (!rsp_valid_reg || rsp.ready);

    ibt_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (CAPACITY)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (free_idx_reg),
        .wdata ({start_reg, end_reg}),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    ibt_overlap u_cmp (
        .slot_entry (rd_entry),
        .req_start  (start_reg),
        .req_end    (end_reg),
        .hit        (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            start_reg        <= '0;
            end_reg          <= '0;
            idx_reg          <= '0;
            free_idx_reg     <= '0;
            have_free_reg    <= 1'b0;
            clash_reg        <= 1'b0;
            p_vld_reg        <= 1'b0;
            p_slot_valid_reg <= 1'b0;
            slot_valid_reg   <= '0;
            held_count_reg   <= '0;
            result_reg       <= ST_BOOKED;
            rsp_valid_reg    <= 1'b0;
            rsp_status_reg   <= ST_BOOKED;
            rsp_booked_reg   <= '0;
        end
        else
        begin
            if (reply_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            // compare stage: RAM data of the previous read
            if (p_vld_reg && p_slot_valid_reg && hit)
            begin
                clash_reg <= 1'b1;
            end
            p_vld_reg <= (state_reg == S_SCAN);

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        start_reg     <= req_start;
                        end_reg       <= req_end;
                        idx_reg       <= '0;
                        clash_reg     <= 1'b0;
                        have_free_reg <= 1'b0;
                        if (req_start >= req_end)
                        begin
                            result_reg <= ST_EMPTY;
                            state_reg  <= S_REPLY;
                        end
                        else
                        begin
                            state_reg <= S_SCAN;
                        end
                    end
                end
                S_SCAN:
                begin
                    p_slot_valid_reg <= slot_valid_reg[idx_reg];
                    // lowest free slot comes first in scan order
                    if (!slot_valid_reg[idx_reg] && !have_free_reg)
                    begin
                        have_free_reg <= 1'b1;
                        free_idx_reg  <= idx_reg;
                    end
                    if (idx_reg == SLOT_BITS'(CAPACITY - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    // overlap wins over full
                    if (clash_reg)
                    begin
                        result_reg <= ST_OVERLAP;
                    end
                    else if (!have_free_reg)
                    begin
                        result_reg <= ST_FULL;
                    end
                    else
                    begin
                        result_reg                   <= ST_BOOKED;
                        slot_valid_reg[free_idx_reg] <= 1'b1;
                        held_count_reg               <= held_count_reg + 1'b1;
                    end
                    state_reg <= S_REPLY;
                end
                S_REPLY:
                begin
                    if (reply_load)
                    begin
                        rsp_status_reg <= result_reg;
                        rsp_booked_reg <= BOOKED_BITS'(held_count_reg);
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.booked_count = rsp_booked_reg;

    // count tracks the valid bits
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(slot_valid_reg) == int'(held_count_reg))
        else $error("held count differs from number of valid slots");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(held_count_reg) <= CAPACITY)
        else $error("held count above capacity");

    // never overwrite a booked slot
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !slot_valid_reg[free_idx_reg])
        else $error("booking written over a valid slot");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> !req.ready)
        else $error("ready high right after an accepted item");

endmodule
